// ----- sv/htw_pkg.sv -----
// ----------------------------------------------------------------------------
// htw_pkg
// Shared types and constants for the hierarchical timing wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int NEAR_BITS  = 8;
  localparam int LEVEL_BITS = 6;
  localparam int POOL_SIZE  = 64;
  localparam int NUM_LEVELS = 4;
  localparam int LVL_SEL_W  = 2;
  localparam int HANDLE_W   = 6;
  localparam int MAX_POOL   = 64;

  localparam logic [1:0] FN_ADD    = 2'd0;
  localparam logic [1:0] FN_CANCEL = 2'd1;
  localparam logic [1:0] FN_TICK   = 2'd2;

  localparam logic [2:0] K_SCHED   = 3'd0;
  localparam logic [2:0] K_FIRED   = 3'd1;
  localparam logic [2:0] K_EXPIRED = 3'd2;
  localparam logic [2:0] K_FULL    = 3'd3;
  localparam logic [2:0] K_ACK     = 3'd4;
  localparam logic [2:0] K_DONE    = 3'd5;

  typedef struct packed {
    logic                v;
    logic [HANDLE_W-1:0] idx;
  } link_t;

  typedef struct packed {
    logic                v;
    logic [HANDLE_W-1:0] head;
    logic [HANDLE_W-1:0] tail;
  } slot_t;

  typedef struct packed {
    logic [31:0] expire;
    logic [15:0] owner;
    logic [7:0]  tag;
  } rec_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [HANDLE_W-1:0] handle;
    logic [15:0]         owner;
    logic [7:0]          tag;
    logic                last;
  } res_t;

endpackage

// ----- sv/htw_ram.sv -----
// ----------------------------------------------------------------------------
// htw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/hierarchical_timing_wheel.sv -----
// ----------------------------------------------------------------------------
// hierarchical_timing_wheel
// Five-level timing wheel over a pool of timer entries.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word: func selects add, cancel
// or tick. Add takes delay/owner_id/callback_tag, cancel takes handle.
// Output channel (out_valid/out_ready) returns result words; last marks the
// final word of an input word. Func 3 is dropped without a result.
// One input word is in work at a time; in_ready is high only when idle.
// Cancel and fired-now/pool-full adds go straight to the result; a scheduled
// add links its entry into a slot; a tick expires near slots and cascades a
// due coarser slot. Every step is one read-modify-write on the slot-head
// memories and the entry link/record memories, each with registered reads.
// A result word sits in an output register; expired words are staged one
// deep so last can be set. A stalled receiver holds the sequencer only when
// a new word must move into the output register.
// After reset the slot-head memories are cleared, one slot per cycle, until
// every address of both is written; in_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module hierarchical_timing_wheel #(
  parameter int NEAR_BITS  = htw_pkg::NEAR_BITS,
  parameter int LEVEL_BITS = htw_pkg::LEVEL_BITS,
  parameter int POOL_SIZE  = htw_pkg::POOL_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] delay,
  input  logic [15:0] owner_id,
  input  logic [7:0]  callback_tag,
  input  logic [5:0]  handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [5:0]  entry_handle,
  output logic [15:0] owner_out,
  output logic [7:0]  tag_out,
  output logic        last
);

  localparam int NAW   = NEAR_BITS;
  localparam int LAW   = LEVEL_BITS + htw_pkg::LVL_SEL_W;
  localparam int CLR_W = (NAW > LAW) ? NAW : LAW;
  localparam int PAW   = $clog2(POOL_SIZE);
  localparam int SLOT_W = $bits(htw_pkg::slot_t);
  localparam int LINK_W = $bits(htw_pkg::link_t);
  localparam int REC_W  = $bits(htw_pkg::rec_t);
  localparam int SH1 = NEAR_BITS + LEVEL_BITS;
  localparam int SH2 = NEAR_BITS + 2 * LEVEL_BITS;
  localparam int SH3 = NEAR_BITS + 3 * LEVEL_BITS;
  localparam logic [33:0] LIM0 = 34'd1 << NEAR_BITS;
  localparam logic [33:0] LIM1 = 34'd1 << SH1;
  localparam logic [33:0] LIM2 = 34'd1 << SH2;
  localparam logic [33:0] LIM3 = 34'd1 << SH3;
  localparam logic [63:0] FREE_INIT = 64'((65'd1 << POOL_SIZE) - 65'd1);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_FINAL    = 13'b0000000000100,
    S_PL_RD    = 13'b0000000001000,
    S_PL_WR    = 13'b0000000010000,
    S_CAS_RD   = 13'b0000000100000,
    S_CAS_HD   = 13'b0000001000000,
    S_CAS_NEXT = 13'b0000010000000,
    S_CAS_REC  = 13'b0000100000000,
    S_EXP_RD   = 13'b0001000000000,
    S_EXP_HD   = 13'b0010000000000,
    S_EXP_NEXT = 13'b0100000000000,
    S_EXP_REC  = 13'b1000000000000
  } state_t;

  state_t               state;
  logic [CLR_W-1:0]     clr_cnt;
  logic [31:0]          wheel_time;
  logic [63:0]          free_map;
  logic [63:0]          cancel_map;
  logic                 op_tick;
  logic                 phase;
  htw_pkg::link_t       cur;
  logic [5:0]           cur_e;
  logic [31:0]          cur_exp;
  logic                 pl_near;
  logic [NAW-1:0]       pl_naddr;
  logic [LAW-1:0]       pl_laddr;
  logic [LAW-1:0]       cas_addr;
  logic                 pend_valid;
  htw_pkg::res_t        pend;
  htw_pkg::res_t        res;

  // memory ports
  logic                 n_we, n_re, l_we, l_re, x_we, x_re, r_we, r_re;
  logic [NAW-1:0]       n_waddr, n_raddr;
  logic [LAW-1:0]       l_waddr, l_raddr;
  logic [PAW-1:0]       x_waddr, x_raddr, r_waddr, r_raddr;
  htw_pkg::slot_t       n_wdata, n_rdata, l_wdata, l_rdata, hd;
  htw_pkg::link_t       x_wdata, x_rdata;
  htw_pkg::rec_t        r_wdata, r_rdata;

  logic                 in_acc, out_free, nonpos, any_free, emit_exp;
  logic [5:0]           alloc;
  logic [31:0]          ct;
  logic                 cas_found;
  logic [1:0]           cas_lvl;
  logic [LEVEL_BITS-1:0] cas_idx;
  logic [33:0]          ahead;
  logic                 tgt_near;
  logic [LAW-1:0]       tgt_laddr;
  logic                 push;
  htw_pkg::res_t        push_w;

  htw_ram #(.WIDTH(SLOT_W), .DEPTH(1 << NAW)) u_near (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .re(n_re), .raddr(n_raddr), .rdata(n_rdata)
  );
  htw_ram #(.WIDTH(SLOT_W), .DEPTH(1 << LAW)) u_level (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
  );
  htw_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SIZE)) u_next (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .re(x_re), .raddr(x_raddr), .rdata(x_rdata)
  );
  htw_ram #(.WIDTH(REC_W), .DEPTH(POOL_SIZE)) u_rec (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .re(r_re), .raddr(r_raddr), .rdata(r_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign nonpos   = (delay == 32'd0) || delay[31];
  assign ct       = wheel_time + 32'd1;
  assign hd       = pl_near ? n_rdata : l_rdata;
  assign emit_exp = !cancel_map[cur_e];

  always_comb begin
    any_free = 1'b0;
    alloc    = '0;
    for (int i = 63; i >= 0; i--) begin
      if (free_map[i]) begin
        any_free = 1'b1;
        alloc    = 6'(i);
      end
    end
  end

  // cascade slot chosen after the time step
  always_comb begin
    logic        run;
    logic [63:0] ct64;
    logic [LEVEL_BITS-1:0] idx;
    run       = 1'b1;
    ct64      = 64'(ct);
    cas_found = 1'b0;
    cas_lvl   = '0;
    cas_idx   = '0;
    for (int l = 0; l < htw_pkg::NUM_LEVELS; l++) begin
      idx = LEVEL_BITS'(ct64 >> (NEAR_BITS + l * LEVEL_BITS));
      if (run && !cas_found) begin
        if ((ct64 & ((64'd1 << (NEAR_BITS + l * LEVEL_BITS)) - 64'd1)) != 64'd0) begin
          run = 1'b0;
        end else if (idx != '0) begin
          cas_found = 1'b1;
          cas_lvl   = 2'(l);
          cas_idx   = idx;
        end
      end
    end
  end

  // placement target
  always_comb begin
    logic [63:0] e64;
    e64  = 64'(cur_exp);
    ahead = {2'b00, cur_exp - wheel_time};
    tgt_near = ahead < LIM0;
    if (ahead < LIM1) begin
      tgt_laddr = {2'd0, LEVEL_BITS'(e64 >> NEAR_BITS)};
    end else if (ahead < LIM2) begin
      tgt_laddr = {2'd1, LEVEL_BITS'(e64 >> SH1)};
    end else if (ahead < LIM3) begin
      tgt_laddr = {2'd2, LEVEL_BITS'(e64 >> SH2)};
    end else begin
      tgt_laddr = {2'd3, LEVEL_BITS'(e64 >> SH3)};
    end
  end

  always_comb begin
    n_we = 1'b0; n_re = 1'b0; l_we = 1'b0; l_re = 1'b0;
    x_we = 1'b0; x_re = 1'b0; r_we = 1'b0; r_re = 1'b0;
    n_waddr = '0; n_raddr = '0; l_waddr = '0; l_raddr = '0;
    x_waddr = '0; x_raddr = '0; r_waddr = '0; r_raddr = '0;
    n_wdata = '0; l_wdata = '0; x_wdata = '0;
    r_wdata = '{expire: wheel_time + delay, owner: owner_id, tag: callback_tag};
    push   = 1'b0;
    push_w = pend;
    case (state)
      S_CLEAR: begin
        n_we    = 1'b1;
        n_waddr = clr_cnt[NAW-1:0];
        l_we    = 1'b1;
        l_waddr = clr_cnt[LAW-1:0];
      end
      S_IDLE: begin
        if (in_acc && func == htw_pkg::FN_ADD && !nonpos && any_free) begin
          r_we    = 1'b1;
          r_waddr = alloc[PAW-1:0];
        end
      end
      S_FINAL: begin
        push = out_free;
        if (pend_valid) begin
          push_w      = pend;
          push_w.last = 1'b1;
        end else begin
          push_w = '{kind: htw_pkg::K_DONE, handle: '0, owner: '0, tag: '0, last: 1'b1};
        end
      end
      S_PL_RD: begin
        x_we    = 1'b1;
        x_waddr = cur_e[PAW-1:0];
        if (tgt_near) begin
          n_re    = 1'b1;
          n_raddr = cur_exp[NAW-1:0];
        end else begin
          l_re    = 1'b1;
          l_raddr = tgt_laddr;
        end
      end
      S_PL_WR: begin
        if (hd.v) begin
          x_we    = 1'b1;
          x_waddr = hd.tail[PAW-1:0];
          x_wdata = '{v: 1'b1, idx: cur_e};
          n_wdata = '{v: 1'b1, head: hd.head, tail: cur_e};
        end else begin
          n_wdata = '{v: 1'b1, head: cur_e, tail: cur_e};
        end
        l_wdata = n_wdata;
        n_waddr = pl_naddr;
        l_waddr = pl_laddr;
        n_we    = pl_near;
        l_we    = !pl_near;
      end
      S_CAS_RD: begin
        l_re    = 1'b1;
        l_raddr = cas_addr;
      end
      S_CAS_HD: begin
        l_we    = 1'b1;
        l_waddr = cas_addr;
      end
      S_CAS_NEXT, S_EXP_NEXT: begin
        x_re    = cur.v;
        r_re    = cur.v;
        x_raddr = cur.idx[PAW-1:0];
        r_raddr = cur.idx[PAW-1:0];
      end
      S_EXP_RD: begin
        n_re    = 1'b1;
        n_raddr = wheel_time[NAW-1:0];
      end
      S_EXP_HD: begin
        n_we    = 1'b1;
        n_waddr = wheel_time[NAW-1:0];
      end
      S_EXP_REC: begin
        if (emit_exp && pend_valid && out_free) begin
          push        = 1'b1;
          push_w      = pend;
          push_w.last = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      wheel_time <= '0;
      free_map   <= FREE_INIT;
      cancel_map <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
        res       <= push_w;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            case (func)
              htw_pkg::FN_ADD: begin
                pend_valid <= 1'b1;
                op_tick    <= 1'b0;
                if (nonpos) begin
                  pend  <= '{kind: htw_pkg::K_FIRED, handle: '0, owner: owner_id,
                             tag: callback_tag, last: 1'b0};
                  state <= S_FINAL;
                end else if (!any_free) begin
                  pend  <= '{kind: htw_pkg::K_FULL, handle: '0, owner: '0, tag: '0,
                             last: 1'b0};
                  state <= S_FINAL;
                end else begin
                  free_map[alloc]   <= 1'b0;
                  cancel_map[alloc] <= 1'b0;
                  cur_e   <= alloc;
                  cur_exp <= wheel_time + delay;
                  pend    <= '{kind: htw_pkg::K_SCHED, handle: alloc, owner: '0,
                               tag: '0, last: 1'b0};
                  state   <= S_PL_RD;
                end
              end
              htw_pkg::FN_CANCEL: begin
                if ({1'b0, handle} < 7'(POOL_SIZE) && !free_map[handle]) begin
                  cancel_map[handle] <= 1'b1;
                end
                pend_valid <= 1'b1;
                pend  <= '{kind: htw_pkg::K_ACK, handle: handle, owner: '0, tag: '0,
                           last: 1'b0};
                state <= S_FINAL;
              end
              htw_pkg::FN_TICK: begin
                op_tick <= 1'b1;
                phase   <= 1'b0;
                state   <= S_EXP_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_FINAL: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_PL_RD: begin
          pl_near  <= tgt_near;
          pl_naddr <= cur_exp[NAW-1:0];
          pl_laddr <= tgt_laddr;
          state    <= S_PL_WR;
        end
        S_PL_WR: begin
          state <= op_tick ? S_CAS_NEXT : S_FINAL;
        end
        S_CAS_RD: state <= S_CAS_HD;
        S_CAS_HD: begin
          cur   <= '{v: l_rdata.v, idx: l_rdata.head};
          state <= S_CAS_NEXT;
        end
        S_CAS_NEXT: begin
          if (cur.v) begin
            cur_e <= cur.idx;
            state <= S_CAS_REC;
          end else begin
            phase <= 1'b1;
            state <= S_EXP_RD;
          end
        end
        S_CAS_REC: begin
          cur     <= x_rdata;
          cur_exp <= r_rdata.expire;
          state   <= S_PL_RD;
        end
        S_EXP_RD: state <= S_EXP_HD;
        S_EXP_HD: begin
          cur   <= '{v: n_rdata.v, idx: n_rdata.head};
          state <= S_EXP_NEXT;
        end
        S_EXP_NEXT: begin
          if (cur.v) begin
            cur_e <= cur.idx;
            state <= S_EXP_REC;
          end else if (phase) begin
            state <= S_FINAL;
          end else begin
            wheel_time <= ct;
            phase      <= 1'b1;
            if (ct == 32'd0) begin
              cas_addr <= {2'd3, LEVEL_BITS'(0)};
              phase    <= 1'b0;
              state    <= S_CAS_RD;
            end else if (cas_found) begin
              cas_addr <= {cas_lvl, cas_idx};
              phase    <= 1'b0;
              state    <= S_CAS_RD;
            end else begin
              state <= S_EXP_RD;
            end
          end
        end
        S_EXP_REC: begin
          if (!(emit_exp && pend_valid && !out_free)) begin
            free_map[cur_e] <= 1'b1;
            cur             <= x_rdata;
            state           <= S_EXP_NEXT;
            if (emit_exp) begin
              pend_valid <= 1'b1;
              pend <= '{kind: htw_pkg::K_EXPIRED, handle: cur_e, owner: r_rdata.owner,
                        tag: r_rdata.tag, last: 1'b0};
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign kind         = res.kind;
  assign entry_handle = res.handle;
  assign owner_out    = res.owner;
  assign tag_out      = res.tag;
  assign last         = res.last;

`ifndef NO_ASSERTIONS
  a_time_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(wheel_time) |-> $past(state == S_EXP_NEXT))
    else $error("wheel time moved outside the tick step");

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    (free_map & ~FREE_INIT) == 64'd0)
    else $error("free map marks an entry beyond the pool");

  a_cancel_final: assert property (@(posedge clk) disable iff (rst)
    in_acc && func == htw_pkg::FN_CANCEL |=> state == S_FINAL && pend_valid)
    else $error("cancel did not queue its ack");

  a_final_push: assert property (@(posedge clk) disable iff (rst)
    state == S_FINAL && out_free |=> out_valid && last)
    else $error("final word not delivered with last");
`endif

endmodule
